[rtl/decision_forest_classifier_defines.svh]
// Assertion macros used by the checker of the forest classifier.
`ifndef DECISION_FOREST_CLASSIFIER_DEFINES_SVH
`define DECISION_FOREST_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("dfc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DFC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("dfc assertion failed");

`endif

[rtl/dfc_pkg.sv]
`timescale 1ns / 1ps
package dfc_pkg;

	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	localparam logic [5:0] TREES_RESET = 6'd22;

	typedef struct packed {
		logic               operation;
		logic [4:0]         tree_index;
		logic [7:0]         node_index;
		logic [2:0]         node_feature;
		logic signed [31:0] node_threshold;
		logic [7:0]         node_left;
		logic [7:0]         node_right;
		logic [2:0]         node_class;
		logic signed [31:0] rr_gap;
		logic signed [31:0] peak_level;
		logic signed [31:0] beat_spread;
		logic signed [31:0] beat_power;
	} item_t;

	typedef struct packed {
		logic [2:0] predicted_class;
		logic [5:0] winning_votes;
		logic       walk_limit_hit;
	} result_t;

	typedef struct packed {
		logic [2:0]         feature;
		logic signed [31:0] threshold;
		logic [7:0]         left;
		logic [7:0]         right;
		logic [2:0]         leaf_class;
	} node_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EVAL,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic mem_write;
		logic start;
		logic rd_en;
		logic vote;
		logic drop;
		logic step;
		logic scan;
		logic deliver;
	} cmd_t;

	typedef struct packed {
		logic op_classify;
		logic count_zero;
		logic leaf;
		logic drop;
		logic last_tree;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

[rtl/dfc_node_mem.sv]
`timescale 1ns / 1ps
module dfc_node_mem #(
	parameter int AW = 13
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  dfc_pkg::node_t wdata,
	input  logic           re,
	input  logic [AW-1:0]  raddr,
	output dfc_pkg::node_t rdata
);

	dfc_pkg::node_t mem [1 << AW];
	dfc_pkg::node_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/dfc_ctrl.sv]
`timescale 1ns / 1ps
module dfc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  dfc_pkg::sts_t sts,
	output dfc_pkg::cmd_t cmd
);

	dfc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = (state_q != dfc_pkg::ST_IDLE);
		unique case (state_q)
			dfc_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (sts.op_classify) begin
						cmd.start = 1'b1;
						state_d   = dfc_pkg::ST_FETCH;
					end else begin
						cmd.mem_write = 1'b1;
						state_d       = dfc_pkg::ST_DONE;
					end
				end
			end
			dfc_pkg::ST_FETCH: begin
				// With no tree in use the walk is skipped and all counts stay zero.
				if (sts.count_zero) begin
					state_d = dfc_pkg::ST_SCAN;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = dfc_pkg::ST_EVAL;
				end
			end
			dfc_pkg::ST_EVAL: begin
				if (sts.leaf || sts.drop) begin
					cmd.vote = sts.leaf;
					cmd.drop = !sts.leaf;
					state_d  = sts.last_tree ? dfc_pkg::ST_SCAN : dfc_pkg::ST_FETCH;
				end else begin
					cmd.step = 1'b1;
					state_d  = dfc_pkg::ST_FETCH;
				end
			end
			dfc_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = dfc_pkg::ST_DONE;
				end
			end
			dfc_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.deliver = 1'b1;
					state_d     = dfc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dfc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/dfc_datapath.sv]
`timescale 1ns / 1ps
module dfc_datapath #(
	parameter int MAX_TREES      = 32,
	parameter int NODES_PER_TREE = 256,
	parameter int NUM_CLASSES    = 6,
	parameter int NUM_FEATURES   = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dfc_pkg::item_t   item_word,
	input  logic             result_stall,
	output logic             result_valid,
	output dfc_pkg::result_t result_word,
	input  logic             cfg_we,
	input  logic [5:0]       cfg_wdata,
	input  dfc_pkg::cmd_t    cmd,
	output dfc_pkg::sts_t    sts
);

	localparam int TW  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
	localparam int NW  = $clog2(NODES_PER_TREE);
	localparam int AW  = TW + NW;
	localparam int TCW = $clog2(MAX_TREES + 1);
	localparam int MCW = $clog2(NODES_PER_TREE + 1);
	localparam int CW  = $clog2(NUM_CLASSES);
	localparam int VCW = $clog2(MAX_TREES + 1);

	logic [5:0]     trees_in_use_q;
	logic [TCW-1:0] count_q;
	logic [TCW-1:0] tree_q;
	logic [NW-1:0]  node_q;
	logic [MCW-1:0] moves_q;
	logic [31:0]    feat_q [4];
	logic [VCW-1:0] votes_q [NUM_CLASSES];
	logic [CW-1:0]  scan_idx_q;
	logic [CW-1:0]  best_q;
	logic [VCW-1:0] best_cnt_q;
	logic           hit_q;
	logic           classify_q;
	logic           result_valid_q;
	dfc_pkg::result_t result_q;

	dfc_pkg::node_t nd;
	dfc_pkg::node_t wr_node;
	logic           wr_ok;
	logic [AW-1:0]  wr_addr;
	logic [AW-1:0]  rd_addr;
	logic [31:0]    feat_val;
	logic           go_left;
	logic [7:0]     child;
	logic           class_ok;

	always_comb begin
		wr_node.feature    = item_word.node_feature;
		wr_node.threshold  = item_word.node_threshold;
		wr_node.left       = item_word.node_left;
		wr_node.right      = item_word.node_right;
		wr_node.leaf_class = item_word.node_class;
	end

	assign wr_ok = (32'(item_word.tree_index) < MAX_TREES) &&
		(32'(item_word.node_index) < NODES_PER_TREE);
	assign wr_addr = {TW'(item_word.tree_index), NW'(item_word.node_index)};
	assign rd_addr = {tree_q[TW-1:0], node_q};

	dfc_node_mem #(
		.AW(AW)
	) u_mem (
		.clk  (clk),
		.we   (cmd.mem_write && wr_ok),
		.waddr(wr_addr),
		.wdata(wr_node),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(nd)
	);

	// Node test: signed compare of the selected feature against the split value.
	assign feat_val = feat_q[nd.feature[1:0]];
	assign go_left  = $signed(feat_val) <= $signed(nd.threshold);
	assign child    = go_left ? nd.left : nd.right;
	assign class_ok = 32'(nd.leaf_class) < NUM_CLASSES;

	always_comb begin
		sts.op_classify = (item_word.operation == dfc_pkg::OP_CLASSIFY);
		sts.count_zero  = (count_q == '0);
		sts.leaf        = (32'(nd.feature) >= NUM_FEATURES);
		sts.drop        = (32'(moves_q) >= NODES_PER_TREE) || (32'(child) >= NODES_PER_TREE);
		sts.last_tree   = ((tree_q + 1'b1) == count_q);
		sts.scan_last   = (scan_idx_q == CW'(NUM_CLASSES - 1));
		sts.out_free    = !result_valid_q || !result_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trees_in_use_q <= dfc_pkg::TREES_RESET;
		end else if (cfg_we) begin
			trees_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			feat_q[0]  <= item_word.rr_gap;
			feat_q[1]  <= item_word.peak_level;
			feat_q[2]  <= item_word.beat_spread;
			feat_q[3]  <= item_word.beat_power;
			count_q    <= (32'(trees_in_use_q) > MAX_TREES) ? TCW'(MAX_TREES) :
				TCW'(trees_in_use_q);
			tree_q     <= '0;
			node_q     <= '0;
			moves_q    <= '0;
			hit_q      <= 1'b0;
			scan_idx_q <= '0;
			best_q     <= '0;
			best_cnt_q <= '0;
			classify_q <= 1'b1;
			for (int k = 0; k < NUM_CLASSES; k++) begin
				votes_q[k] <= '0;
			end
		end
		if (cmd.mem_write) begin
			classify_q <= 1'b0;
		end
		if (cmd.step) begin
			node_q  <= NW'(child);
			moves_q <= moves_q + 1'b1;
		end
		if (cmd.vote || cmd.drop) begin
			tree_q  <= tree_q + 1'b1;
			node_q  <= '0;
			moves_q <= '0;
		end
		if (cmd.drop) begin
			hit_q <= 1'b1;
		end
		if (cmd.vote && class_ok) begin
			for (int k = 0; k < NUM_CLASSES; k++) begin
				if (32'(nd.leaf_class) == k) begin
					votes_q[k] <= votes_q[k] + 1'b1;
				end
			end
		end
		// Strictly greater keeps the lowest class index on a tie.
		if (cmd.scan) begin
			if (votes_q[scan_idx_q] > best_cnt_q) begin
				best_q     <= scan_idx_q;
				best_cnt_q <= votes_q[scan_idx_q];
			end
			scan_idx_q <= scan_idx_q + 1'b1;
		end
		if (cmd.deliver) begin
			if (classify_q) begin
				result_q.predicted_class <= 3'(best_q);
				result_q.winning_votes   <= 6'(best_cnt_q);
				result_q.walk_limit_hit  <= hit_q;
			end else begin
				result_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_q;

endmodule

[rtl/decision_forest_classifier.sv]
`timescale 1ns / 1ps
// Channel    Direction  Handshake                   Word
// item       in         item_valid / item_stall     dfc_pkg::item_t
// result     out        result_valid / result_stall dfc_pkg::result_t
// cfg        in         cfg_we                      cfg_wdata (trees_in_use)
//
// A node write passes through ST_DONE and is answered with an all-zero result word.
// A classification walks every tree in use from node 0, and the walk is skipped with no tree
// in use: each node visit is one memory read in ST_FETCH plus one evaluate in ST_EVAL,
// and the vote tally is then scanned in ST_SCAN one class per cycle.
// Node memory is not cleared by reset; trees_in_use resets to 22. One word is in flight
// at a time; a stalled result holds, and the next word is taken once it is registered.
module decision_forest_classifier #(
	parameter int MAX_TREES      = 32,
	parameter int NODES_PER_TREE = 256,
	parameter int NUM_CLASSES    = 6,
	parameter int NUM_FEATURES   = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  dfc_pkg::item_t   item_word,
	output logic             result_valid,
	input  logic             result_stall,
	output dfc_pkg::result_t result_word,
	input  logic             cfg_we,
	input  logic [5:0]       cfg_wdata
);

	dfc_pkg::cmd_t cmd;
	dfc_pkg::sts_t sts;

	dfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dfc_datapath #(
		.MAX_TREES     (MAX_TREES),
		.NODES_PER_TREE(NODES_PER_TREE),
		.NUM_CLASSES   (NUM_CLASSES),
		.NUM_FEATURES  (NUM_FEATURES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_word   (item_word),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.result_word (result_word),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

[rtl/dfc_checker.sv]
`timescale 1ns / 1ps
`include "decision_forest_classifier_defines.svh"
module dfc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input dfc_pkg::item_t   item_word,
	input logic             result_valid,
	input logic             result_stall,
	input dfc_pkg::result_t result_word,
	input logic             cfg_we
);

	logic item_acc;
	logic item_wr;

	assign item_acc = item_valid && !item_stall;
	assign item_wr  = item_acc && (item_word.operation == dfc_pkg::OP_WRITE);

	// Only one word is worked on at a time.
	`DFC_ASSERT_NEXT(a_one_in_flight, clk, arst_n, item_acc, item_stall)
	// A fresh result is only produced while the input side is busy with its word.
	`DFC_ASSERT_NOW(a_result_from_work, clk, arst_n, $rose(result_valid), $past(item_stall))
	// A write word whose result register is free in the next cycle returns all zeros.
	`DFC_ASSERT_NEXT(a_write_zero, clk, arst_n,
		item_wr ##1 (!result_valid || !result_stall), result_valid && (result_word == '0))
	// A stalled result word holds.
	`DFC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(result_word))
	// The tree count only changes while nothing is in flight.
	`DFC_ASSERT_NOW(a_cfg_idle, clk, arst_n, cfg_we, !item_stall && !result_valid)

endmodule

bind decision_forest_classifier dfc_checker u_dfc_checker (.*);
